### rtl/probabilistic_approximate_counter_defines.svh
// Assertion macros for the probabilistic approximate counter checks.
`ifndef PROBABILISTIC_APPROXIMATE_COUNTER_DEFINES_SVH
`define PROBABILISTIC_APPROXIMATE_COUNTER_DEFINES_SVH

// Same-cycle implication.
`define PAC_ASSERT_IMP(label, clk, off, ante, cons) \
    label: assert property (@(posedge clk) disable iff (off) (ante) |-> (cons)) \
        else $error("pac check failed");

// Next-cycle implication.
`define PAC_ASSERT_NXT(label, clk, off, ante, cons) \
    label: assert property (@(posedge clk) disable iff (off) (ante) |=> (cons)) \
        else $error("pac check failed");

`endif

### rtl/pac_pkg.sv
// Shared types and constants for the probabilistic approximate counter.
`default_nettype none

package pac_pkg;

    localparam int COUNTER_BITS = 16;
    localparam int RANDOM_BITS  = 32;
    localparam int RAND_SHIFT   = 32 - RANDOM_BITS;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
    localparam logic [32:0] PROB_ONE   = 33'h1_0000_0000;
    localparam logic [63:0] GROWTH_ONE = 64'h0000_0001_0000_0000;

    localparam logic [31:0] SCALE_A_RESET       = 32'd1966080;
    localparam logic [47:0] GROWTH_FACTOR_RESET = 48'd4438236641;
    localparam logic [31:0] SHRINK_FACTOR_RESET = 32'd4156496348;

    typedef enum logic [1:0] {
        REG_SCALE_A       = 2'd0,
        REG_GROWTH_FACTOR = 2'd1,
        REG_SHRINK_FACTOR = 2'd2
    } pac_reg_idx_t;

    typedef struct packed {
        logic [31:0] scale_a;
        logic [47:0] growth_factor;
        logic [31:0] shrink_factor;
    } pac_cfg_t;

    typedef struct packed {
        logic [31:0] random_word;
        logic        end_of_batch;
    } pac_item_t;

    typedef struct packed {
        logic [15:0] register_value;
        logic        advanced;
        logic [63:0] growth_term;
        logic        saturated;
        logic        batch_done;
    } pac_event_t;

    typedef struct packed {
        logic [15:0] register_value;
        logic        advanced;
        logic [63:0] estimate;
        logic        saturated;
        logic        batch_done;
    } pac_result_t;

endpackage

`default_nettype wire

### rtl/pac_cfg_regs.sv
// APB configuration registers of the probabilistic approximate counter.
`default_nettype none

module pac_cfg_regs
    import pac_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output pac_cfg_t                   cfg
);

    pac_cfg_t     cfg_reg;
    pac_cfg_t     cfg_next;
    pac_reg_idx_t idx;
    logic         wr_en;

    assign idx    = pac_reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_SCALE_A:       cfg_next.scale_a       = pwdata[31:0];
                REG_GROWTH_FACTOR: cfg_next.growth_factor = pwdata[47:0];
                REG_SHRINK_FACTOR: cfg_next.shrink_factor = pwdata[31:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SCALE_A:       prdata = CFG_DATA_W'(cfg_reg.scale_a);
            REG_GROWTH_FACTOR: prdata = CFG_DATA_W'(cfg_reg.growth_factor);
            REG_SHRINK_FACTOR: prdata = CFG_DATA_W'(cfg_reg.shrink_factor);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale_a       <= SCALE_A_RESET;
            cfg_reg.growth_factor <= GROWTH_FACTOR_RESET;
            cfg_reg.shrink_factor <= SHRINK_FACTOR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/pac_state_update.sv
// Counter, advance probability and growth term update, one item per cycle while out_ready holds.
`default_nettype none

module pac_state_update
    import pac_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire pac_cfg_t  cfg,
    input  wire logic      in_valid,
    input  wire pac_item_t in_item,
    output logic           in_ready,
    output logic           out_valid,
    output pac_event_t     out_event,
    input  wire logic      out_ready
);

    logic [COUNTER_BITS-1:0] cnt_reg, cnt_next;
    logic [32:0]             prob_reg, prob_next;
    logic [63:0]             grow_reg, grow_next;
    logic                    ev_valid_reg, ev_valid_next;
    pac_event_t              ev_reg, ev_next;

    logic                    take;
    logic [31:0]             frac;
    logic                    adv;
    logic [63:0]             prob_prod;
    logic [32:0]             prob_adv;
    logic [63:0]             p_ll, p_hl;
    logic [47:0]             p_lh, p_hh;
    logic [111:0]            grow_prod;
    logic [63:0]             grow_adv;
    logic [COUNTER_BITS-1:0] cnt_new;
    logic [32:0]             prob_new;
    logic [63:0]             grow_new;
    logic [31:0]             cnt_wide;

    assign in_ready  = !ev_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = ev_valid_reg;
    assign out_event = ev_reg;

    always_comb begin
        frac = in_item.random_word << RAND_SHIFT;
        adv  = (cnt_reg != CNT_MAX) && ({1'b0, frac} < prob_reg);

        // prob is at most 1.0, so its top bit only ever stands alone
        prob_prod = prob_reg[31:0] * cfg.shrink_factor;
        prob_adv  = (prob_reg[32] ? {1'b0, cfg.shrink_factor} : 33'd0)
                  + {1'b0, prob_prod[63:32]};

        p_ll = grow_reg[31:0]  * cfg.growth_factor[31:0];
        p_lh = grow_reg[31:0]  * cfg.growth_factor[47:32];
        p_hl = grow_reg[63:32] * cfg.growth_factor[31:0];
        p_hh = grow_reg[63:32] * cfg.growth_factor[47:32];
        grow_prod = 112'(p_ll) + (112'(p_lh) << 32) + (112'(p_hl) << 32)
                  + (112'(p_hh) << 64);
        grow_adv  = (|grow_prod[111:96]) ? '1 : grow_prod[95:32];

        cnt_new  = adv ? cnt_reg + COUNTER_BITS'(1) : cnt_reg;
        prob_new = adv ? prob_adv : prob_reg;
        grow_new = adv ? grow_adv : grow_reg;
        cnt_wide = 32'(cnt_new);

        ev_next.register_value = cnt_wide[15:0];
        ev_next.advanced       = adv;
        ev_next.growth_term    = grow_new;
        ev_next.saturated      = (cnt_new == CNT_MAX) || (grow_new == '1);
        ev_next.batch_done     = in_item.end_of_batch;

        cnt_next      = cnt_reg;
        prob_next     = prob_reg;
        grow_next     = grow_reg;
        ev_valid_next = ev_valid_reg;
        if (in_ready) begin
            ev_valid_next = in_valid;
        end
        if (take) begin
            if (in_item.end_of_batch) begin
                cnt_next  = '0;
                prob_next = PROB_ONE;
                grow_next = GROWTH_ONE;
            end else begin
                cnt_next  = cnt_new;
                prob_next = prob_new;
                grow_next = grow_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            prob_reg     <= PROB_ONE;
            grow_reg     <= GROWTH_ONE;
            ev_valid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            prob_reg     <= prob_next;
            grow_reg     <= grow_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ev_reg <= ev_next;
        end
    end

endmodule

`default_nettype wire

### rtl/pac_estimate.sv
// Two-stage estimate pipeline: scale_a * (growth - 1) in Q48.16.
`default_nettype none

module pac_estimate
    import pac_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire pac_cfg_t   cfg,
    input  wire logic       in_valid,
    input  wire pac_event_t in_event,
    output logic            in_ready,
    output logic            out_valid,
    output pac_result_t     out_result,
    input  wire logic       out_ready
);

    logic        pp_valid_reg, pp_valid_next;
    logic        res_valid_reg, res_valid_next;
    pac_event_t  meta_reg;
    logic [63:0] pp_lo_reg, pp_lo_next;
    logic [63:0] pp_hi_reg, pp_hi_next;
    pac_result_t res_reg, res_next;

    logic        res_ready;
    logic [63:0] excess;
    logic [95:0] est_sum;

    assign res_ready  = !res_valid_reg || out_ready;
    assign in_ready   = !pp_valid_reg || res_ready;
    assign out_valid  = res_valid_reg;
    assign out_result = res_reg;

    always_comb begin
        excess = (in_event.growth_term > GROWTH_ONE) ?
                 in_event.growth_term - GROWTH_ONE : 64'd0;
        pp_lo_next = cfg.scale_a * excess[31:0];
        pp_hi_next = cfg.scale_a * excess[63:32];

        est_sum = {32'd0, pp_lo_reg} + {pp_hi_reg, 32'd0};
        res_next.register_value = meta_reg.register_value;
        res_next.advanced       = meta_reg.advanced;
        res_next.estimate       = est_sum[95:32];
        res_next.saturated      = meta_reg.saturated;
        res_next.batch_done     = meta_reg.batch_done;

        pp_valid_next  = pp_valid_reg;
        res_valid_next = res_valid_reg;
        if (in_ready) begin
            pp_valid_next = in_valid;
        end
        if (res_ready) begin
            res_valid_next = pp_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            pp_valid_reg  <= pp_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            meta_reg  <= in_event;
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
        end
        if (res_ready && pp_valid_reg) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

### rtl/probabilistic_approximate_counter.sv
// Morris approximate counter with logarithmic register; top level.
//
// Every item on the input stream is one counted event with a 32-bit uniform
// random word; every item yields one result with the counter value, an
// advance flag, the Q48.16 estimate scale_a*((1+1/a)^v - 1), a saturation
// flag and tlast echoing the end of batch. The block sustains one item per
// clock unless the output stalls; items pass the input, event and estimate
// registers. The state update sets the rate; its loop is combinational (a
// 32x32 probability multiply and a 64x48 growth product summed from four
// partial products). After the last item of a batch the counter,
// probability and growth term return to their reset values; configuration
// is kept. Registers are at byte addresses 0 (scale_a), 8 (growth_factor),
// 16 (shrink_factor) and must only be written while no item is in flight.
`default_nettype none

module probabilistic_approximate_counter
    import pac_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [31:0]           s_axis_tdata,   // random_word[31:0]
    input  wire logic                  s_axis_tlast,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [79:0]           m_axis_tdata,   // register_value[15:0], estimate[79:16]
    output logic      [1:0]            m_axis_tuser,   // advanced[0], saturated[1]
    output logic                       m_axis_tlast,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    pac_cfg_t    cfg;
    logic        in_valid_reg, in_valid_next;
    pac_item_t   in_item_reg;
    logic        upd_ready;
    logic        ev_valid;
    pac_event_t  ev;
    logic        est_ready;
    pac_result_t res;

    assign s_axis_tready = !in_valid_reg || upd_ready;
    assign in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg.random_word  <= s_axis_tdata;
            in_item_reg.end_of_batch <= s_axis_tlast;
        end
    end

    pac_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pac_state_update u_state_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (in_valid_reg),
        .in_item   (in_item_reg),
        .in_ready  (upd_ready),
        .out_valid (ev_valid),
        .out_event (ev),
        .out_ready (est_ready)
    );

    pac_estimate u_estimate (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (ev_valid),
        .in_event   (ev),
        .in_ready   (est_ready),
        .out_valid  (m_axis_tvalid),
        .out_result (res),
        .out_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {res.estimate, res.register_value};
    assign m_axis_tuser = {res.saturated, res.advanced};
    assign m_axis_tlast = res.batch_done;

endmodule

`default_nettype wire

### rtl/pac_checker.sv
// Port-level checks for the probabilistic approximate counter, bound to the top.
`default_nettype none
`include "probabilistic_approximate_counter_defines.svh"

module pac_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    logic        stall;
    logic [82:0] out_word;
    logic [15:0] out_count;
    logic        adv_flag;
    logic        sat_flag;

    assign stall     = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign out_count = m_axis_tdata[15:0];
    assign adv_flag  = m_axis_tuser[0];
    assign sat_flag  = m_axis_tuser[1];

    `PAC_ASSERT_NXT(a_reset_empty, aclk, 1'b0, !aresetn, !m_axis_tvalid)

    `PAC_ASSERT_NXT(a_out_hold, aclk, !aresetn, stall, m_axis_tvalid && $stable(out_word))

    `PAC_ASSERT_IMP(a_adv_nonzero, aclk, !aresetn, m_axis_tvalid && adv_flag, out_count != 16'd0)

    `PAC_ASSERT_IMP(a_cnt_max_sat, aclk, !aresetn, m_axis_tvalid && !sat_flag, out_count != '1)

endmodule

bind probabilistic_approximate_counter pac_checker u_pac_checker (.*);

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the probabilistic approximate counter.
`default_nettype none

module tb_top;
    import pac_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_PAD   = 10;
    localparam int RAND_ITEMS  = 170;
    localparam logic [1:0] REG_SPARE = 2'd3;   // past the register list, writes ignored

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  reg_sel;
        logic [63:0] value;
        logic [31:0] word;
        logic        last;
        logic        typed;
        pac_result_t want;
    } stim_row_t;

    localparam pac_result_t NO_RESULT = '0;
    localparam int DIR_N = 26;

    localparam stim_row_t DIR_ROWS [DIR_N] = '{
        '{ROW_CFG,  REG_SCALE_A,       64'd0,              32'h0,        1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'hFFFF_FFFF, 1'b0, 1'b1,
          '{16'd1, 1'b1, 64'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'h0,        1'b1, 1'b1,
          '{16'd2, 1'b1, 64'd0, 1'b0, 1'b1}},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'hFFFF_FFFF, 1'b0, 1'b1,
          '{16'd1, 1'b1, 64'd0, 1'b0, 1'b0}},
        '{ROW_CFG,  REG_SHRINK_FACTOR, 64'd0,              32'h0,        1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'h0,        1'b0, 1'b1,
          '{16'd2, 1'b1, 64'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'h0,        1'b0, 1'b1,
          '{16'd2, 1'b0, 64'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'hFFFF_FFFF, 1'b1, 1'b1,
          '{16'd2, 1'b0, 64'd0, 1'b0, 1'b1}},
        '{ROW_CFG,  REG_GROWTH_FACTOR, 64'd0,              32'h0,        1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG,  REG_SHRINK_FACTOR, 64'hFFFF_FFFF,      32'h0,        1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG,  REG_SCALE_A,       64'hFFFF_FFFF,      32'h0,        1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'hFFFF_FFFF, 1'b0, 1'b1,
          '{16'd1, 1'b1, 64'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'h0,        1'b1, 1'b1,
          '{16'd2, 1'b1, 64'd0, 1'b0, 1'b1}},
        '{ROW_CFG,  REG_GROWTH_FACTOR, 64'hFFFF_FFFF_FFFF, 32'h0,        1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'h0,        1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'h0,        1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'h0,        1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'h8000_0000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'h7FFF_FFFF, 1'b1, 1'b0, NO_RESULT},
        '{ROW_CFG,  REG_SPARE,         64'hFFFF_FFFF_FFFF_FFFF, 32'h0,   1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG,  REG_SCALE_A,       64'(SCALE_A_RESET), 32'h0,        1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG,  REG_GROWTH_FACTOR, 64'(GROWTH_FACTOR_RESET), 32'h0,  1'b0, 1'b0, NO_RESULT},
        '{ROW_CFG,  REG_SHRINK_FACTOR, 64'(SHRINK_FACTOR_RESET), 32'h0,  1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'h0,        1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'hFFFF_FFFF, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, REG_SPARE,         64'd0,              32'h0,        1'b1, 1'b0, NO_RESULT}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [79:0]           m_axis_tdata;   // register_value[15:0], estimate[79:16]
    logic [1:0]            m_axis_tuser;   // advanced[0], saturated[1]
    logic                  m_axis_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    probabilistic_approximate_counter uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 aclk = ~aclk;

    pac_cfg_t          cfg_regs;
    logic [15:0]       log_count;
    logic [32:0]       adv_prob;
    logic [63:0]       growth_q;
    pac_result_t       pending_results [$];
    logic              cur_typed = 1'b0;
    pac_result_t       cur_want = '0;
    int                err_count = 0;
    int                cycle_count = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;

    function automatic void restart_batch();
        log_count = '0;
        adv_prob  = PROB_ONE;
        growth_q  = GROWTH_ONE;
    endfunction

    // One counted event: advance test, state update, estimate.
    function automatic pac_result_t count_event(input logic [31:0] word, input logic last);
        pac_result_t  res;
        logic [64:0]  prob_prod;
        logic [111:0] grow_prod;
        logic [95:0]  est_prod;
        res = '0;
        if (log_count != CNT_MAX && {1'b0, word} < adv_prob) begin
            res.advanced = 1'b1;
            log_count = log_count + 16'd1;
            prob_prod = 65'(adv_prob) * 65'(cfg_regs.shrink_factor);
            adv_prob = prob_prod[64:32];
            grow_prod = 112'(growth_q) * 112'(cfg_regs.growth_factor);
            growth_q = (grow_prod[111:96] != '0) ? '1 : grow_prod[95:32];
        end
        if (growth_q > GROWTH_ONE) begin
            est_prod = 96'(cfg_regs.scale_a) * 96'(growth_q - GROWTH_ONE);
            res.estimate = est_prod[95:32];
        end
        res.register_value = log_count;
        res.saturated = (log_count == CNT_MAX) || (growth_q == '1);
        res.batch_done = last;
        if (last)
            restart_batch();
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch %s: got %h, want %h", what, got, want);
        err_count++;
    endtask

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        pac_result_t want;
        pac_result_t pred;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("unexpected result", m_axis_tdata[63:0], '0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[15:0] !== want.register_value)
                        note_mismatch("register_value", m_axis_tdata[15:0], want.register_value);
                    if (m_axis_tuser[0] !== want.advanced)
                        note_mismatch("advanced", m_axis_tuser[0], want.advanced);
                    if (m_axis_tdata[79:16] !== want.estimate)
                        note_mismatch("estimate", m_axis_tdata[79:16], want.estimate);
                    if (m_axis_tuser[1] !== want.saturated)
                        note_mismatch("saturated", m_axis_tuser[1], want.saturated);
                    if (m_axis_tlast !== want.batch_done)
                        note_mismatch("batch_done", m_axis_tlast, want.batch_done);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pred = count_event(s_axis_tdata, s_axis_tlast);
                pending_results.push_back(cur_typed ? cur_want : pred);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[probabilistic_approximate_counter] ERROR");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [31:0] word, input logic last,
                             input logic typed, input pac_result_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= last;
        cur_typed = typed;
        cur_want  = want;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_PAD) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] reg_sel, input logic [63:0] value);
        logic [63:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (reg_sel)
            REG_SCALE_A:       cfg_regs.scale_a = value[31:0];
            REG_GROWTH_FACTOR: cfg_regs.growth_factor = value[47:0];
            REG_SHRINK_FACTOR: cfg_regs.shrink_factor = value[31:0];
            default: ;
        endcase
        if (reg_sel != REG_SPARE) begin
            // read back
            want = (reg_sel == REG_SCALE_A)       ? 64'(cfg_regs.scale_a) :
                   (reg_sel == REG_GROWTH_FACTOR) ? 64'(cfg_regs.growth_factor) :
                                                    64'(cfg_regs.shrink_factor);
            @(negedge aclk);
            psel    <= 1'b1;
            pwrite  <= 1'b0;
            @(negedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            if (prdata !== want)
                note_mismatch("register readback", prdata, want);
            @(negedge aclk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic random_items(input int n);
        logic [31:0] word;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0:       word = '0;
                1:       word = '1;
                2:       word = $urandom_range(255);
                default: word = $urandom;
            endcase
            send_item(word, ($urandom_range(15) == 0), 1'b0, NO_RESULT);
        end
    endtask

    initial begin
        cfg_regs.scale_a       = SCALE_A_RESET;
        cfg_regs.growth_factor = GROWTH_FACTOR_RESET;
        cfg_regs.shrink_factor = SHRINK_FACTOR_RESET;
        restart_batch();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 24;
        recv_idle_pct = 83;
        for (int i = 0; i < DIR_N; i++) begin
            if (DIR_ROWS[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(DIR_ROWS[i].reg_sel, DIR_ROWS[i].value);
            end else begin
                send_item(DIR_ROWS[i].word, DIR_ROWS[i].last, DIR_ROWS[i].typed,
                          DIR_ROWS[i].want);
            end
        end
        random_items(RAND_ITEMS);

        // a = 1.0, growth 2.0, shrink 0.5
        wait_idle();
        send_idle_pct = 83;
        recv_idle_pct = 24;
        write_reg(REG_SCALE_A, 64'h0001_0000);
        write_reg(REG_GROWTH_FACTOR, 64'h2_0000_0000);
        write_reg(REG_SHRINK_FACTOR, 64'h8000_0000);
        random_items(RAND_ITEMS);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_SCALE_A, {32'd0, $urandom});
        write_reg(REG_GROWTH_FACTOR, {16'd0, 16'($urandom), $urandom});
        write_reg(REG_SHRINK_FACTOR, {32'd0, $urandom});
        random_items(RAND_ITEMS);

        // short batches with a near-one shrink factor
        wait_idle();
        write_reg(REG_SCALE_A, 64'(SCALE_A_RESET));
        write_reg(REG_GROWTH_FACTOR, 64'(GROWTH_FACTOR_RESET));
        write_reg(REG_SHRINK_FACTOR, 64'hFFFF_FFFF);
        send_item('0, 1'b1, 1'b0, NO_RESULT);
        send_item('0, 1'b0, 1'b0, NO_RESULT);
        send_item('1, 1'b0, 1'b0, NO_RESULT);
        send_item('0, 1'b1, 1'b0, NO_RESULT);
        send_item('0, 1'b0, 1'b0, NO_RESULT);

        wait_idle();
        if (err_count == 0) begin
            $display("[probabilistic_approximate_counter] OK");
        end else begin
            $display("[probabilistic_approximate_counter] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

### probabilistic_approximate_counter.f
+incdir+rtl
rtl/pac_pkg.sv
rtl/pac_cfg_regs.sv
rtl/pac_state_update.sv
rtl/pac_estimate.sv
rtl/probabilistic_approximate_counter.sv
rtl/pac_checker.sv
sim/tb_top.sv
